// ----- hw/rtl/lhrg_pkg.sv -----
// Shared types, constants and the hash function of the hashed random generator.
package lhrg_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned VALUE_W = 31;

	localparam logic [WORD_W-1:0] SEED_RESET = 32'd987654321;
	localparam logic [WORD_W-1:0] LFSR_TAPS = 32'h4800_0000;
	localparam logic [WORD_W-1:0] MASK31 = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] SCRAMBLE = 32'd71;
	localparam logic [WORD_W-1:0] HC1 = 32'd1376312589;
	localparam logic [WORD_W-1:0] HC2 = 32'd789221;
	localparam logic [WORD_W-1:0] HC3 = 32'd15731;

	localparam int unsigned OP_W = 3;
	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_NONE = 3'd0;
	localparam op_t OP_LFSR = 3'd1;
	localparam op_t OP_SQUARE = 3'd2;
	localparam op_t OP_CUBIC = 3'd3;
	localparam op_t OP_POLY = 3'd4;
	localparam op_t OP_OUT = 3'd5;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
	} stat_t;

	function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] s;
		s = WORD_W'($signed(x) >>> 21);
		return ((x << 13) ^ x) - s;
	endfunction

endpackage

// ----- hw/rtl/lhrg_if.sv -----
// Valid-ready channel interfaces for requests and random values.
interface lhrg_req_if;
	logic valid;
	logic ready;
	logic request;

	modport source(output valid, output request, input ready);
	modport sink(input valid, input request, output ready);
endinterface

interface lhrg_val_if;
	logic valid;
	logic ready;
	logic [lhrg_pkg::VALUE_W-1:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

// ----- hw/rtl/lhrg_ctrl.sv -----
// Controller state machine that sequences the shared multiplier steps.
module lhrg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_request,
	output logic             in_ready,
	input  lhrg_pkg::stat_t  stat,
	output lhrg_pkg::cmd_t   cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LFSR = 3'd1;
	localparam logic [2:0] ST_SQUARE = 3'd2;
	localparam logic [2:0] ST_CUBIC = 3'd3;
	localparam logic [2:0] ST_POLY = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op = lhrg_pkg::OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_request) begin
					state_d = ST_LFSR;
				end
			end
			ST_LFSR: begin
				cmd.op = lhrg_pkg::OP_LFSR;
				state_d = ST_SQUARE;
			end
			ST_SQUARE: begin
				cmd.op = lhrg_pkg::OP_SQUARE;
				state_d = ST_CUBIC;
			end
			ST_CUBIC: begin
				cmd.op = lhrg_pkg::OP_CUBIC;
				state_d = ST_POLY;
			end
			ST_POLY: begin
				cmd.op = lhrg_pkg::OP_POLY;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (stat.slot_free) begin
					cmd.op = lhrg_pkg::OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hw/rtl/lhrg_dp.sv -----
// Datapath with the shift register, seed, shared multiplier and output register.
module lhrg_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lhrg_pkg::WORD_W-1:0]   cfg_wdata,
	input  lhrg_pkg::cmd_t                cmd,
	output lhrg_pkg::stat_t               stat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lhrg_pkg::VALUE_W-1:0]  out_value
);

	logic [lhrg_pkg::WORD_W-1:0] seed_q;
	logic [lhrg_pkg::WORD_W-1:0] sr_q;
	logic [lhrg_pkg::WORD_W-1:0] acc_q;
	logic [lhrg_pkg::WORD_W-1:0] m_q;
	logic [lhrg_pkg::VALUE_W-1:0] value_q;
	logic                         valid_q;

	logic [lhrg_pkg::WORD_W-1:0] base;
	logic [lhrg_pkg::WORD_W-1:0] lfsr_next;
	logic [lhrg_pkg::WORD_W-1:0] mix_acc;
	logic [lhrg_pkg::WORD_W-1:0] mul_a;
	logic [lhrg_pkg::WORD_W-1:0] mul_b;
	logic [lhrg_pkg::WORD_W-1:0] prod;
	logic [lhrg_pkg::WORD_W-1:0] final_word;

	assign base = (sr_q == '0) ? seed_q : sr_q;
	assign lfsr_next = base[0] ? ((base >> 1) ^ lhrg_pkg::LFSR_TAPS) : (base >> 1);
	assign mix_acc = lhrg_pkg::mix(acc_q);
	assign final_word = lhrg_pkg::mix((acc_q & lhrg_pkg::MASK31) + m_q);

	always_comb begin
		mul_a = acc_q;
		mul_b = lhrg_pkg::HC3;
		case (cmd.op)
			lhrg_pkg::OP_LFSR: begin
				mul_a = lfsr_next;
				mul_b = lhrg_pkg::SCRAMBLE;
			end
			lhrg_pkg::OP_SQUARE: begin
				mul_a = mix_acc;
				mul_b = mix_acc;
			end
			lhrg_pkg::OP_POLY: begin
				mul_a = m_q;
				mul_b = acc_q;
			end
			default: begin
				mul_a = acc_q;
				mul_b = lhrg_pkg::HC3;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	assign stat.slot_free = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= lhrg_pkg::SEED_RESET;
			sr_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			if (cmd.op == lhrg_pkg::OP_LFSR) begin
				sr_q <= lfsr_next;
			end
			if (cmd.op == lhrg_pkg::OP_OUT) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			lhrg_pkg::OP_LFSR: begin
				acc_q <= prod;
			end
			lhrg_pkg::OP_SQUARE: begin
				m_q <= mix_acc;
				acc_q <= prod;
			end
			lhrg_pkg::OP_CUBIC: begin
				acc_q <= prod + lhrg_pkg::HC2;
			end
			lhrg_pkg::OP_POLY: begin
				acc_q <= prod + lhrg_pkg::HC1;
			end
			lhrg_pkg::OP_OUT: begin
				value_q <= final_word[lhrg_pkg::VALUE_W-1:0];
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hw/rtl/lfsr_hashed_random_generator.sv -----
// Top level of the shift-register driven hashed random generator.
//
// Each word on the req channel with request set pulls one 31-bit random value,
// delivered as one word on the rsp channel; a word with request clear is taken
// and produces nothing. Software reads value / 2^31 as a fraction in [0,1).
// The seed register is written through cfg_we and cfg_wdata; the user is to write it
// only while the block is idle, as the block does not enforce this. It is loaded into
// the shift register whenever that register reads zero. A request is taken while the
// sequencer is idle; it then steps through the LFSR, square, cubic and poly steps and
// loads its value into the output register in the out step, which raises rsp.valid.
// The scramble product and the three dependent products of the hash share one 32-bit
// multiplier, one product per cycle, so the next request waits for the idle state.
// req.ready is high whenever the sequencer is idle, even while a finished value
// still waits in the output register; if rsp stalls, the next value waits in
// its final step until the output register frees up.
// Reset clears the shift register to zero, restores the seed to 987654321 and
// empties the output register.
module lfsr_hashed_random_generator (
	input  logic                         clk,
	input  logic                         arst_n,
	lhrg_req_if.sink                     req,
	lhrg_val_if.source                   rsp,
	input  logic                         cfg_we,
	input  logic [lhrg_pkg::WORD_W-1:0]  cfg_wdata
);

	lhrg_pkg::cmd_t  cmd;
	lhrg_pkg::stat_t stat;

	lhrg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_request (req.request),
		.in_ready   (req.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	lhrg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_value (rsp.value)
	);

endmodule

// ----- hw/rtl/lhrg_checker.sv -----
// Port-level checks of the hashed random generator and their binding.
module lhrg_sva (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          in_request,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [lhrg_pkg::VALUE_W-1:0]  out_value
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value))
		else $error("Output word dropped or changed while stalled.");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_request |=> !in_ready)
		else $error("Input taken again while a request is in work.");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_request && !out_valid |-> ##6 out_valid)
		else $error("Random value did not appear after the fixed latency.");

	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !in_request && !out_valid |=> !out_valid)
		else $error("A word without request produced a result.");

endmodule

bind lfsr_hashed_random_generator lhrg_sva u_lhrg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.in_request (req.request),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.out_value  (rsp.value)
);
